FILE: rtl/pga_pkg.sv
// ---------------------------------------------------------------------------
// pga_pkg: shared types and constants
// Widths, register codes and the queued item type for the gravity block.
// ---------------------------------------------------------------------------
`default_nettype none

package pga_pkg;

    // Field widths
    localparam int POS_W   = 32;              // Q16.16 positions and results
    localparam int STR_W   = 31;              // strength and radius
    localparam int OFS_W   = POS_W + 1;       // signed offset
    localparam int MAG_W   = OFS_W;           // offset magnitude
    localparam int SQ_W    = 2 * MAG_W;       // one squared magnitude
    localparam int SUM_W   = 68;              // sum of squares and root remainder
    localparam int D_W     = 34;              // distance
    localparam int DD_W    = 2 * D_W;         // distance squared
    localparam int D3_W    = 3 * D_W;         // distance cubed
    localparam int REM_W   = D3_W + 1;        // divider remainder
    localparam int PROD_W  = STR_W + MAG_W;   // strength times magnitude
    localparam int Q_W     = 32;              // quotient bits kept
    localparam int AXES    = 3;

    localparam int SQRT_STEPS = D_W;
    localparam int DIV_STEPS  = Q_W;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    // Stream and register port widths
    localparam int TDATA_W = 96;
    localparam int TUSER_W = 1;
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_SOURCE_X = 3'd0;
    localparam logic [2:0] REG_SOURCE_Y = 3'd1;
    localparam logic [2:0] REG_SOURCE_Z = 3'd2;
    localparam logic [2:0] REG_GRAVITY  = 3'd3;
    localparam logic [2:0] REG_RADIUS   = 3'd4;

    typedef struct packed {
        logic signed [POS_W-1:0] source_x;
        logic signed [POS_W-1:0] source_y;
        logic signed [POS_W-1:0] source_z;
        logic [STR_W-1:0]        gravity_strength;
        logic [STR_W-1:0]        surface_radius;
    } cfg_t;

    // One queued body: offsets from the source, lane 0 is x
    typedef struct packed {
        logic [AXES-1:0][OFS_W-1:0] ofs;
        logic                       phys;
    } item_t;

endpackage : pga_pkg

`default_nettype wire

FILE: rtl/pga_front.sv
// ---------------------------------------------------------------------------
// pga_front: register file and input stage
// Holds the configuration registers, takes input beats and forms the offset
// of each body from the source before it is queued.
// ---------------------------------------------------------------------------
`default_nettype none

module pga_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // register port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pga_pkg::APB_AW-1:0]  paddr,
    input  wire logic [pga_pkg::APB_DW-1:0]  pwdata,
    output logic      [pga_pkg::APB_DW-1:0]  prdata,
    output logic                             pready,
    // input stream
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [pga_pkg::TDATA_W-1:0] s_axis_tdata,  // body_x, body_y, body_z
    input  wire logic [pga_pkg::TUSER_W-1:0] s_axis_tuser,  // physics_on
    // to queue
    output pga_pkg::cfg_t                    cfg,
    output logic                             q_push,
    output pga_pkg::item_t                   q_item,
    input  wire logic                        q_full
);
    import pga_pkg::*;

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic             wr_en;
    logic [2:0]       reg_idx;
    logic [AXES-1:0][POS_W-1:0] src;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_SOURCE_X: cfg_next.source_x = pwdata;
                REG_SOURCE_Y: cfg_next.source_y = pwdata;
                REG_SOURCE_Z: cfg_next.source_z = pwdata;
                REG_GRAVITY:  cfg_next.gravity_strength = pwdata[STR_W-1:0];
                REG_RADIUS:   cfg_next.surface_radius = pwdata[STR_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Register read
    always_comb
    begin
        case (reg_idx)
            REG_SOURCE_X: prdata = cfg_reg.source_x;
            REG_SOURCE_Y: prdata = cfg_reg.source_y;
            REG_SOURCE_Z: prdata = cfg_reg.source_z;
            REG_GRAVITY:  prdata = {1'b0, cfg_reg.gravity_strength};
            REG_RADIUS:   prdata = {1'b0, cfg_reg.surface_radius};
            default:      prdata = '0;
        endcase
    end

    // Input beat: offset from source, sign extended to 33 bits
    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;
    assign src[0]        = cfg_reg.source_x;
    assign src[1]        = cfg_reg.source_y;
    assign src[2]        = cfg_reg.source_z;

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            q_item.ofs[a] = {s_axis_tdata[a*POS_W + POS_W-1], s_axis_tdata[a*POS_W +: POS_W]}
                          - {src[a][POS_W-1], src[a]};
        end
        q_item.phys = s_axis_tuser[0];
    end

endmodule : pga_front

`default_nettype wire

FILE: rtl/pga_fifo.sv
// ---------------------------------------------------------------------------
// pga_fifo: item queue
// Short queue between the front and the arithmetic pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

module pga_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire pga_pkg::item_t push_item,
    output logic                full,
    input  wire logic           pop,
    output pga_pkg::item_t      pop_item,
    output logic                empty
);
    import pga_pkg::*;

    item_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic [FIFO_AW:0]   count_next;

    assign full     = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule : pga_fifo

`default_nettype wire

FILE: rtl/pga_back.sv
// ---------------------------------------------------------------------------
// pga_back: acceleration pipeline
// Squares, a bit-per-stage square root, the cube of the distance and three
// bit-per-stage dividers, followed by saturation and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module pga_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire pga_pkg::cfg_t               cfg,
    // from queue
    input  wire pga_pkg::item_t              q_item,
    input  wire logic                        q_empty,
    output logic                             q_pop,
    // output stream
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic      [pga_pkg::TDATA_W-1:0] m_axis_tdata,  // accel_x, accel_y, accel_z
    output logic      [pga_pkg::TUSER_W-1:0] m_axis_tuser   // apply
);
    import pga_pkg::*;

    typedef struct packed {
        logic [AXES-1:0][MAG_W-1:0] mag;
        logic [AXES-1:0]            neg;
        logic                       phys;
    } side_t;

    logic adv;

    // stage A: magnitudes
    logic  a_vld_reg;
    side_t a_side_reg;
    side_t a_side_next;
    // stage B: squares
    logic  b_vld_reg;
    side_t b_side_reg;
    logic [AXES-1:0][SQ_W-1:0] b_sq_reg;
    // square root stages
    logic             rt_vld_reg  [SQRT_STEPS+1];
    side_t            rt_side_reg [SQRT_STEPS+1];
    logic [SUM_W-1:0] rt_rem_reg  [SQRT_STEPS+1];
    logic [D_W-1:0]   rt_res_reg  [SQRT_STEPS+1];
    // distance squared and apply
    logic             md_vld_reg;
    side_t            md_side_reg;
    logic [D_W-1:0]   md_d_reg;
    logic [DD_W-1:0]  md_dd_reg;
    logic             md_apply_reg;
    logic             md_apply_next;
    // partial products
    logic             mp_vld_reg;
    logic [AXES-1:0]  mp_neg_reg;
    logic             mp_apply_reg;
    logic [DD_W-1:0]  mp_plo_reg;
    logic [DD_W-1:0]  mp_phi_reg;
    logic [AXES-1:0][PROD_W-1:0] mp_prod_reg;
    // distance cubed
    logic             mc_vld_reg;
    logic [AXES-1:0]  mc_neg_reg;
    logic             mc_apply_reg;
    logic [D3_W-1:0]  mc_d3_reg;
    logic [AXES-1:0][PROD_W-1:0] mc_prod_reg;
    // divider stages
    logic             dv_vld_reg   [DIV_STEPS+1];
    logic [AXES-1:0]  dv_neg_reg   [DIV_STEPS+1];
    logic [AXES-1:0]  dv_ovf_reg   [DIV_STEPS+1];
    logic             dv_apply_reg [DIV_STEPS+1];
    logic [D3_W-1:0]  dv_d3_reg    [DIV_STEPS+1];
    logic [AXES-1:0][REM_W-1:0] dv_rem_reg [DIV_STEPS+1];
    logic [AXES-1:0][Q_W-1:0]   dv_q_reg   [DIV_STEPS+1];
    // output
    logic                    out_vld_reg;
    logic [TDATA_W-1:0]      out_data_reg;
    logic                    out_apply_reg;
    logic [TDATA_W-1:0]      out_data_next;

    // Whole pipeline moves when the output register is free or drained
    assign adv           = !out_vld_reg || m_axis_tready;
    assign q_pop         = adv && !q_empty;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_apply_reg;

    // Stage A: magnitude and result sign per axis
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            a_side_next.mag[a] = q_item.ofs[a][OFS_W-1] ? (~q_item.ofs[a] + 1'b1)
                                                         : q_item.ofs[a];
            a_side_next.neg[a] = !q_item.ofs[a][OFS_W-1] && (q_item.ofs[a] != '0);
        end
        a_side_next.phys = q_item.phys;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg      <= 1'b0;
            b_vld_reg      <= 1'b0;
            rt_vld_reg[0]  <= 1'b0;
            md_vld_reg     <= 1'b0;
            mp_vld_reg     <= 1'b0;
            mc_vld_reg     <= 1'b0;
            dv_vld_reg[0]  <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg      <= !q_empty;
            b_vld_reg      <= a_vld_reg;
            rt_vld_reg[0]  <= b_vld_reg;
            md_vld_reg     <= rt_vld_reg[SQRT_STEPS];
            mp_vld_reg     <= md_vld_reg;
            mc_vld_reg     <= mp_vld_reg;
            dv_vld_reg[0]  <= mc_vld_reg;
            out_vld_reg    <= dv_vld_reg[DIV_STEPS];
        end
    end

    // Stages A, B, C: magnitudes, squares, sum of squares
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_side_reg <= a_side_next;
            b_side_reg <= a_side_reg;
            for (int a = 0; a < AXES; a++)
            begin
                b_sq_reg[a] <= SQ_W'(a_side_reg.mag[a]) * SQ_W'(a_side_reg.mag[a]);
            end
            rt_side_reg[0] <= b_side_reg;
            rt_rem_reg[0]  <= SUM_W'(b_sq_reg[0]) + SUM_W'(b_sq_reg[1]) + SUM_W'(b_sq_reg[2]);
            rt_res_reg[0]  <= '0;
        end
    end

    // Square root, one result bit per stage, most significant first
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        localparam int B = SQRT_STEPS - 1 - k;
        logic [SUM_W-1:0] trial;
        logic [SUM_W-1:0] rem_next;
        logic [D_W-1:0]   res_next;

        always_comb
        begin
            trial    = (SUM_W'(rt_res_reg[k]) << (B + 1)) + (SUM_W'(1) << (2 * B));
            rem_next = rt_rem_reg[k];
            res_next = rt_res_reg[k];
            if (rt_rem_reg[k] >= trial)
            begin
                rem_next = rt_rem_reg[k] - trial;
                res_next = rt_res_reg[k] | (D_W'(1) << B);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rt_vld_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                rt_vld_reg[k+1] <= rt_vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rt_side_reg[k+1] <= rt_side_reg[k];
                rt_rem_reg[k+1]  <= rem_next;
                rt_res_reg[k+1]  <= res_next;
            end
        end
    end

    // Apply decision and distance squared
    assign md_apply_next = rt_side_reg[SQRT_STEPS].phys
                        && (rt_res_reg[SQRT_STEPS] != '0)
                        && (rt_res_reg[SQRT_STEPS] > D_W'(cfg.surface_radius));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            md_side_reg  <= rt_side_reg[SQRT_STEPS];
            md_d_reg     <= rt_res_reg[SQRT_STEPS];
            md_dd_reg    <= DD_W'(rt_res_reg[SQRT_STEPS]) * DD_W'(rt_res_reg[SQRT_STEPS]);
            md_apply_reg <= md_apply_next;
            // partial products of the cube, strength times magnitude
            mp_neg_reg   <= md_side_reg.neg;
            mp_apply_reg <= md_apply_reg;
            mp_plo_reg   <= DD_W'(md_dd_reg[D_W-1:0]) * DD_W'(md_d_reg);
            mp_phi_reg   <= DD_W'(md_dd_reg[DD_W-1:D_W]) * DD_W'(md_d_reg);
            for (int a = 0; a < AXES; a++)
            begin
                mp_prod_reg[a] <= PROD_W'(cfg.gravity_strength) * PROD_W'(md_side_reg.mag[a]);
            end
            // distance cubed
            mc_neg_reg   <= mp_neg_reg;
            mc_apply_reg <= mp_apply_reg;
            mc_prod_reg  <= mp_prod_reg;
            mc_d3_reg    <= D3_W'(mp_plo_reg) + (D3_W'(mp_phi_reg) << D_W);
            // divider setup: quotient of 2^32 or more saturates
            dv_neg_reg[0]   <= mc_neg_reg;
            dv_apply_reg[0] <= mc_apply_reg;
            dv_d3_reg[0]    <= mc_d3_reg;
            for (int a = 0; a < AXES; a++)
            begin
                dv_ovf_reg[0][a] <= (D3_W'(mc_prod_reg[a]) >= mc_d3_reg);
                dv_rem_reg[0][a] <= REM_W'(mc_prod_reg[a]);
                dv_q_reg[0][a]   <= '0;
            end
        end
    end

    // Restoring division, one quotient bit per stage on each axis
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        logic [AXES-1:0][REM_W-1:0] rem_next;
        logic [AXES-1:0][Q_W-1:0]   q_next;
        logic [AXES-1:0][REM_W-1:0] shl;

        always_comb
        begin
            for (int a = 0; a < AXES; a++)
            begin
                shl[a] = dv_rem_reg[k][a] << 1;
                if (shl[a] >= REM_W'(dv_d3_reg[k]))
                begin
                    rem_next[a] = shl[a] - REM_W'(dv_d3_reg[k]);
                    q_next[a]   = {dv_q_reg[k][a][Q_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[a] = shl[a];
                    q_next[a]   = {dv_q_reg[k][a][Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_vld_reg[k+1] <= dv_vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_neg_reg[k+1]   <= dv_neg_reg[k];
                dv_ovf_reg[k+1]   <= dv_ovf_reg[k];
                dv_apply_reg[k+1] <= dv_apply_reg[k];
                dv_d3_reg[k+1]    <= dv_d3_reg[k];
                dv_rem_reg[k+1]   <= rem_next;
                dv_q_reg[k+1]     <= q_next;
            end
        end
    end

    // Saturate, apply sign, zero when not applied
    always_comb
    begin
        logic [Q_W-1:0] lim;
        logic [Q_W-1:0] mag;
        out_data_next = '0;
        for (int a = 0; a < AXES; a++)
        begin
            lim = dv_neg_reg[DIV_STEPS][a] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            mag = dv_q_reg[DIV_STEPS][a];
            if (dv_ovf_reg[DIV_STEPS][a] || (mag > lim))
            begin
                mag = lim;
            end
            if (dv_apply_reg[DIV_STEPS])
            begin
                out_data_next[a*POS_W +: POS_W] = dv_neg_reg[DIV_STEPS][a] ? (Q_W'(0) - mag)
                                                                            : mag;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg  <= out_data_next;
            out_apply_reg <= dv_apply_reg[DIV_STEPS];
        end
    end

endmodule : pga_back

`default_nettype wire

FILE: rtl/point_gravity_acceleration.sv
// ---------------------------------------------------------------------------
// point_gravity_acceleration: inverse-square point-source gravity
// Per body: offset from the source, distance, acceleration -G*r/d^3 per axis.
// ---------------------------------------------------------------------------
// Usage: one body position per input beat gives one acceleration beat, in
// order. The block sustains one beat per clock while the output is not
// stalled. Most of its pipeline depth is the 34-stage square root and the
// 32-stage dividers, each resolving one bit per stage. A four-entry queue
// sits between the input side and the pipeline, and the whole pipeline holds
// while the output beat is not taken. Registers are to be written over the
// APB port only while no beat is in flight; the block does not enforce this.
// When apply is low, the three acceleration fields are zero.
`default_nettype none

module point_gravity_acceleration (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pga_pkg::APB_AW-1:0]  paddr,
    input  wire logic [pga_pkg::APB_DW-1:0]  pwdata,
    output logic      [pga_pkg::APB_DW-1:0]  prdata,
    output logic                             pready,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [pga_pkg::TDATA_W-1:0] s_axis_tdata,  // body_x, body_y, body_z
    input  wire logic [pga_pkg::TUSER_W-1:0] s_axis_tuser,  // physics_on
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic      [pga_pkg::TDATA_W-1:0] m_axis_tdata,  // accel_x, accel_y, accel_z
    output logic      [pga_pkg::TUSER_W-1:0] m_axis_tuser   // apply
);
    import pga_pkg::*;

    cfg_t  cfg;
    item_t push_item;
    item_t pop_item;
    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;

    pga_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cfg           (cfg),
        .q_push        (q_push),
        .q_item        (push_item),
        .q_full        (q_full)
    );

    pga_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    pga_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .q_item        (pop_item),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Queue never written when full
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("queue push while full");

    // Queue never read when empty
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("queue pop while empty");

    // A beat that is not applied carries zero acceleration
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("nonzero acceleration without apply");

endmodule : point_gravity_acceleration

`default_nettype wire
